// File: src/kcts_pkg.sv
// Shared constants for the keyed color table shuffle block.
// No dependencies; imported by the top level and its checker.
package kcts_pkg;

    localparam int TableDepth = 256;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int ColorW     = 24;
    localparam int KeyWords   = 4;
    localparam int KeyWordW   = 64;
    localparam int AddrW      = 5;
    localparam int DataW      = 64;
    localparam int GreenMul   = 7;
    localparam int BlueMul    = 13;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Initial table entry before the shuffle: (i, 7i mod 256, 13i mod 256)
    function automatic logic [ColorW-1:0] init_color(input logic [IdxW-1:0] i);
        logic [IdxW-1:0] g;
        logic [IdxW-1:0] b;
        g = IdxW'(i * IdxW'(GreenMul));
        b = IdxW'(i * IdxW'(BlueMul));
        return {i, g, b};
    endfunction

endpackage

// File: src/keyed_color_table_shuffle.sv
// Keyed color table shuffle: top level with sequencer, shared divider and table RAM.
// Depends on kcts_pkg.
//
// A build transfer (cmd 0) fills the 256 x 24-bit color table with
// (i, 7i, 13i) and then runs a keyed Fisher-Yates pass from entry 255 down
// to 1, swapping entry i with j = (key[i mod 32] xor i) mod (i+1). After
// the fill, each swap steps through loading the dividend, the restoring
// divider that produces one remainder bit per cycle, a RAM read and two
// writes through the single RAM write port. A read transfer (cmd 1) is a
// registered RAM read followed by loading the output register, which waits
// while the output register still holds a result. s_ready is high only while the
// sequencer is idle; a finished result may still wait in the output register
// while the next item is accepted. Reads before the first build return zero
// colors with table_ready clear. Key words sit at byte addresses 0, 8, 16, 24
// and must be written only while the block is idle; the block does not enforce this.
module keyed_color_table_shuffle (
    input  logic                        aclk,
    input  logic                        aresetn,
    // command channel
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [kcts_pkg::IdxW-1:0]   s_entry_index,
    // result channel
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_red,
    output logic [7:0]                  m_green,
    output logic [7:0]                  m_blue,
    output logic                        m_table_ready,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kcts_pkg::AddrW-1:0]  paddr,
    input  logic [kcts_pkg::DataW-1:0]  pwdata,
    output logic [kcts_pkg::DataW-1:0]  prdata,
    output logic                        pready
);
    import kcts_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_DLOAD = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SWRD  = 3'd4;
    localparam logic [2:0] ST_SWWI  = 3'd5;
    localparam logic [2:0] ST_SWWJ  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;
    // read result pending uses its own flag alongside idle
    localparam int StepW = $clog2(IdxW);

    logic [KeyWordW-1:0] key_reg [KeyWords];
    logic [2:0]          state_reg, state_next;
    logic [IdxW-1:0]     i_reg, i_next;
    logic [IdxW-1:0]     dvd_reg, dvd_next;
    logic [IdxW-1:0]     rem_reg, rem_next;
    logic [StepW-1:0]    step_reg, step_next;
    logic                rdpend_reg, rdpend_next;
    logic                built_reg, built_next;

    logic                m_valid_reg, m_valid_next;
    logic [ColorW-1:0]   m_color_reg, m_color_next;
    logic                m_tr_reg, m_tr_next;

    logic [ColorW-1:0]   mem [TableDepth];
    logic [ColorW-1:0]   rda_data_reg, rdb_data_reg;
    logic [IdxW-1:0]     rda_addr, rdb_addr;
    logic                rd_en;
    logic                wr_en;
    logic [IdxW-1:0]     wr_addr;
    logic [ColorW-1:0]   wr_data;

    logic                s_fire;
    logic                out_free;
    logic [IdxW:0]       divisor;
    logic [IdxW:0]       trial;
    logic [7:0]          key_byte;
    logic [1:0]          key_sel;
    logic [KeyWordW-1:0] key_word;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = key_reg[paddr[AddrW-1:3]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < KeyWords; k++) key_reg[k] <= '0;
        end else if (psel && penable && pwrite) begin
            key_reg[paddr[AddrW-1:3]] <= pwdata;
        end
    end

    // key byte i mod 32 = byte (i mod 8) of word (i / 8) mod 4
    assign key_sel  = i_reg[4:3];
    assign key_word = key_reg[key_sel];
    assign key_byte = key_word[{i_reg[2:0], 3'b000} +: 8];

    // ---------------- shared divider datapath ----------------
    assign divisor = {1'b0, i_reg} + (IdxW+1)'(1);
    assign trial   = {rem_reg, dvd_reg[IdxW-1]};

    // ---------------- handshake ----------------
    assign s_ready  = (state_reg == ST_IDLE) && !rdpend_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        rdpend_next  = rdpend_reg;
        built_next   = built_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_color_next = m_color_reg;
        m_tr_next    = m_tr_reg;
        rd_en        = 1'b0;
        rda_addr     = i_reg;
        rdb_addr     = rem_reg;
        wr_en        = 1'b0;
        wr_addr      = i_reg;
        wr_data      = rdb_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (rdpend_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_color_next = built_reg ? rda_data_reg : '0;
                        m_tr_next    = built_reg;
                        rdpend_next  = 1'b0;
                    end
                end else if (s_fire) begin
                    if (s_cmd == CMD_READ) begin
                        rd_en       = 1'b1;
                        rda_addr    = s_entry_index;
                        rdpend_next = 1'b1;
                    end else begin
                        i_next     = '0;
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = init_color(i_reg);
                if (i_reg == IdxW'(TableDepth - 1)) begin
                    state_next = ST_DLOAD;
                end else begin
                    i_next = i_reg + IdxW'(1);
                end
            end
            ST_DLOAD: begin
                dvd_next   = key_byte ^ i_reg;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // one restoring step: remainder stays below the divisor (<= 256)
                if (trial >= divisor) rem_next = IdxW'(trial - divisor);
                else                  rem_next = trial[IdxW-1:0];
                dvd_next  = dvd_reg << 1;
                step_next = step_reg + StepW'(1);
                if (step_reg == StepW'(IdxW - 1)) state_next = ST_SWRD;
            end
            ST_SWRD: begin
                rd_en      = 1'b1;
                rda_addr   = i_reg;
                rdb_addr   = rem_reg;
                state_next = ST_SWWI;
            end
            ST_SWWI: begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rdb_data_reg;
                state_next = ST_SWWJ;
            end
            ST_SWWJ: begin
                wr_en   = 1'b1;
                wr_addr = rem_reg;
                wr_data = rda_data_reg;
                if (i_reg == IdxW'(1)) begin
                    state_next = ST_DONE;
                end else begin
                    i_next     = i_reg - IdxW'(1);
                    state_next = ST_DLOAD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_color_next = '0;
                    m_tr_next    = 1'b1;
                    built_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rdpend_reg  <= 1'b0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rdpend_reg  <= rdpend_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        m_color_reg <= m_color_next;
        m_tr_reg    <= m_tr_next;
    end

    // ---------------- color table RAM ----------------
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rda_data_reg <= mem[rda_addr];
            rdb_data_reg <= mem[rdb_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = m_color_reg[23:16];
    assign m_green       = m_color_reg[15:8];
    assign m_blue        = m_color_reg[7:0];
    assign m_table_ready = m_tr_reg;

endmodule

// File: src/kcts_checker.sv
// Port-level checker for keyed_color_table_shuffle, attached by bind.
// Depends on kcts_pkg.
module kcts_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        s_cmd,
    input logic [kcts_pkg::IdxW-1:0]   s_entry_index,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [7:0]                  m_red,
    input logic [7:0]                  m_green,
    input logic [7:0]                  m_blue,
    input logic                        m_table_ready,
    input logic                        pready
);
    import kcts_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
            && $stable(m_blue) && $stable(m_table_ready))
        else $error("result changed while stalled");

    // no table yet means zero color
    a_zero_unbuilt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_table_ready |-> m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0)
        else $error("nonzero color without a built table");

    // one item at a time: busy right after a transfer
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted back-to-back items");

    // a build runs the table fill first, so the input stays closed while it runs
    a_build_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_BUILD |=> !s_ready ##1 !s_ready)
        else $error("input reopened during build");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind keyed_color_table_shuffle kcts_checker u_kcts_checker (.*);

// File: tb/tb_keyed_color_table_shuffle.sv
// Testbench for keyed_color_table_shuffle: directed and random build/read traffic,
// key writes over APB between phases, results checked against a behavioral table model.
// Depends on kcts_pkg and the keyed_color_table_shuffle RTL.
`timescale 1ns / 100ps

module tb_keyed_color_table_shuffle;
    import kcts_pkg::*;

    localparam int ClkPeriod     = 10;
    localparam int KeyWordStride = 8;
    localparam int LongHold      = 500;
    localparam int TimeLimitNs   = 10_000_000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       table_ready;
    } color_result_t;

    // Holds the predicted table and the results still owed by the block.
    class color_scoreboard;
        logic [KeyWordW-1:0] key_words[KeyWords];
        logic [ColorW-1:0]   colors[TableDepth];
        bit                  built;
        color_result_t       expected_colors[$];
        int                  errors;

        function new();
            foreach (key_words[w]) key_words[w] = '0;
            built  = 0;
            errors = 0;
        endfunction

        function void set_key(int w, logic [KeyWordW-1:0] value);
            key_words[w] = value;
        endfunction

        function void rebuild_table();
            int i;
            int j;
            int k;
            logic [7:0] kb;
            logic [ColorW-1:0] t;
            for (i = 0; i < TableDepth; i++)
                colors[i] = {8'(i), 8'(i * GreenMul), 8'(i * BlueMul)};
            for (i = TableDepth - 1; i > 0; i--) begin
                k  = i % 32;
                kb = key_words[k >> 3][(k & 7) * 8 +: 8];
                j  = (int'(kb) ^ i) % (i + 1);
                t         = colors[i];
                colors[i] = colors[j];
                colors[j] = t;
            end
        endfunction

        function void note_command(logic cmd, logic [IdxW-1:0] idx);
            color_result_t r;
            if (cmd == CMD_BUILD) begin
                rebuild_table();
                built = 1;
                r = '{red: 8'd0, green: 8'd0, blue: 8'd0, table_ready: 1'b1};
            end else if (!built) begin
                r = '{red: 8'd0, green: 8'd0, blue: 8'd0, table_ready: 1'b0};
            end else begin
                r = '{red: colors[idx][23:16], green: colors[idx][15:8],
                      blue: colors[idx][7:0], table_ready: 1'b1};
            end
            expected_colors.push_back(r);
        endfunction

        function void check_result(color_result_t got);
            color_result_t exp_c;
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d ready=%0d",
                         $time, got.red, got.green, got.blue, got.table_ready);
                errors++;
                return;
            end
            exp_c = expected_colors.pop_front();
            if (got !== exp_c) begin
                $display("%0t: mismatch expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
                         $time, exp_c.red, exp_c.green, exp_c.blue, exp_c.table_ready,
                         got.red, got.green, got.blue, got.table_ready);
                errors++;
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_cmd;
    logic [IdxW-1:0]     s_entry_index;
    logic                m_valid;
    logic                m_ready;
    logic [7:0]          m_red;
    logic [7:0]          m_green;
    logic [7:0]          m_blue;
    logic                m_table_ready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [AddrW-1:0]    paddr;
    logic [DataW-1:0]    pwdata;
    logic [DataW-1:0]    prdata;
    logic                pready;

    bit hold_req = 0;
    color_scoreboard sb = new();

    keyed_color_table_shuffle dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_entry_index (s_entry_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_table_ready (m_table_ready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #(ClkPeriod / 2) aclk = ~aclk;
    end

    initial begin
        #(TimeLimitNs);
        $display("DONE: errors detected");
        $finish;
    end

    // Both channels are observed at the edge where the transfer happens.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_command(s_cmd, s_entry_index);
            if (m_valid && m_ready)
                sb.check_result('{red: m_red, green: m_green, blue: m_blue,
                                  table_ready: m_table_ready});
        end
    end

    // Receiver: segments of always-ready, random and patterned stalls; a long
    // hold-off on request so the block backs up into its input.
    initial begin
        int seg;
        int mode;
        forever begin
            if (hold_req) begin
                hold_req = 0;
                for (int k = 0; k < LongHold; k++) begin
                    m_ready <= 1'b0;
                    @(posedge aclk);
                end
            end
            seg  = $urandom_range(10, 150);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < seg; k++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 9) != 0);
                    default: m_ready <= ((k % 8) < 3);
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(logic cmd, logic [IdxW-1:0] idx);
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_entry_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Leaves the bus selected; the caller closes it after the last write.
    task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic load_key(logic [KeyWordW-1:0] w0, logic [KeyWordW-1:0] w1,
                            logic [KeyWordW-1:0] w2, logic [KeyWordW-1:0] w3);
        logic [KeyWordW-1:0] words[KeyWords];
        words = '{w0, w1, w2, w3};
        for (int w = 0; w < KeyWords; w++) begin
            apb_write(AddrW'(w * KeyWordStride), words[w]);
            sb.set_key(w, words[w]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Key writes are only legal once every owed result is back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_items(int count, int build_pct);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && sent < count; b++) begin
                if ($urandom_range(0, 99) < build_pct)
                    send_item(CMD_BUILD, IdxW'($urandom));
                else
                    send_item(CMD_READ, IdxW'($urandom));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) idle_sender(gap);
        end
        idle_sender(1);
    endtask

    function automatic logic [KeyWordW-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_cmd         <= CMD_READ;
        s_entry_index <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reads before any build come back zero with table_ready clear
        send_item(CMD_READ, 8'd0);
        send_item(CMD_READ, 8'd255);
        send_item(CMD_READ, 8'hA5);
        // build with the reset key; index is ignored on build
        send_item(CMD_BUILD, 8'd255);
        send_item(CMD_READ, 8'd0);
        send_item(CMD_READ, 8'd255);
        send_item(CMD_READ, 8'd1);
        drain();

        load_key('1, '1, '1, '1);
        send_item(CMD_BUILD, 8'd0);
        send_item(CMD_READ, 8'd0);
        send_item(CMD_READ, 8'd255);
        send_item(CMD_READ, 8'h80);
        drain();

        // new key leaves the stored table alone until the next build
        load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                 64'h0F0F_F0F0_55AA_AA55, 64'h8000_0000_0000_0001);
        send_item(CMD_READ, 8'd0);
        send_item(CMD_READ, 8'd255);
        send_item(CMD_BUILD, 8'h5A);
        send_item(CMD_READ, 8'd0);
        send_item(CMD_READ, 8'd255);
        send_item(CMD_READ, 8'd7);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: load_key(rand_word(), rand_word(), rand_word(), rand_word());
                1: load_key({4{16'hAAAA}}, {4{16'h5555}}, {4{16'hAAAA}}, {4{16'h5555}});
                2: load_key(rand_word(), '0, rand_word(), '1);
                default: load_key(rand_word(), rand_word(), rand_word(), rand_word());
            endcase
            if (phase % 2 == 1) hold_req = 1;
            send_item(CMD_BUILD, IdxW'($urandom));
            run_items(99, 4);
            drain();
        end

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
